[rtl/dsu_pkg.sv]
package dsu_pkg;

	// Forest size and node index width
	localparam int NODES  = 64;
	localparam int NODE_W = $clog2(NODES);

	typedef logic [NODE_W-1:0] node_t;

	// Request kinds carried on the input tuser bit
	localparam logic REQ_UNION = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_COMP = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	// Parent table access: one read request and one write request
	typedef struct packed {
		logic  rd_en;
		node_t rd_addr;
		logic  wr_en;
		node_t wr_addr;
		node_t wr_data;
	} tbl_req_t;

endpackage

[rtl/dsu_ram.sv]
module dsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/dsu_table.sv]
module dsu_table (
	input  logic              clk,
	input  logic              arst_n,
	input  dsu_pkg::tbl_req_t req,
	output dsu_pkg::node_t    rd_data
);

	logic [dsu_pkg::NODES-1:0] vld_q;
	dsu_pkg::node_t            ram_rdata;
	dsu_pkg::node_t            addr_s1;
	dsu_pkg::node_t            wdat_s1;
	logic                      vld_s1;
	logic                      fwd_s1;

	dsu_ram #(
		.WIDTH(dsu_pkg::NODE_W),
		.DEPTH(dsu_pkg::NODES)
	) u_ram (
		.clk  (clk),
		.we   (req.wr_en),
		.waddr(req.wr_addr),
		.wdata(req.wr_data),
		.re   (req.rd_en),
		.raddr(req.rd_addr),
		.rdata(ram_rdata)
	);

	// Mark entries written since reset; unwritten entries read as their own index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.wr_addr] <= 1'b1;
		end
	end

	// Capture read context; forward a write to the same entry in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (req.rd_en) begin
			vld_s1 <= vld_q[req.rd_addr];
			fwd_s1 <= req.wr_en && (req.wr_addr == req.rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			addr_s1 <= req.rd_addr;
			wdat_s1 <= req.wr_data;
		end
	end

	assign rd_data = fwd_s1 ? wdat_s1 : (vld_s1 ? ram_rdata : addr_s1);

endmodule

[rtl/disjoint_set_union_engine.sv]
// Sequence: each find walks parent steps up to the root and then rewrites the nodes on
//   that path by path compression; node_a is found first, then node_b, then the done step.
// Flow: one item at a time; the next item is taken once the sequencer is back in idle,
//   and the done step holds while a result is still waiting on the output. Each step
//   makes at most one parent read.
// Reset: arst_n clears control and the table valid bits, so every node is its
//   own root right after reset with no clearing pass.
module disjoint_set_union_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [5:0] node_a, [11:6] node_b, [15:12] zero
	input  logic        s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [5:0] root_a, [7:6] zero
	output logic        m_axis_tuser   // [0] same_set
);

	dsu_pkg::state_t   state_q;
	dsu_pkg::tbl_req_t tbl;
	dsu_pkg::node_t    rd_data;
	dsu_pkg::node_t    cur_q;
	dsu_pkg::node_t    start_q;
	dsu_pkg::node_t    root_q;
	dsu_pkg::node_t    ra_q;
	dsu_pkg::node_t    rb_q;
	dsu_pkg::node_t    b_q;
	dsu_pkg::node_t    in_a;
	dsu_pkg::node_t    in_b;
	dsu_pkg::node_t    found_root;
	dsu_pkg::node_t    lo_root;
	dsu_pkg::node_t    hi_root;
	dsu_pkg::node_t    out_root_q;
	logic              out_same_q;
	logic              out_vld_q;
	logic              req_q;
	logic              which_q;
	logic              accept;
	logic              find_done;
	logic              out_free;

	dsu_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl),
		.rd_data(rd_data)
	);

	// Indexes reduce modulo the forest size
	assign in_a     = s_axis_tdata[dsu_pkg::NODE_W-1:0];
	assign in_b     = s_axis_tdata[6 +: dsu_pkg::NODE_W];
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_vld_q || m_axis_tready;
	assign lo_root  = (ra_q < rb_q) ? ra_q : rb_q;
	assign hi_root  = (ra_q < rb_q) ? rb_q : ra_q;

	assign s_axis_tready = (state_q == dsu_pkg::S_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(8 - dsu_pkg::NODE_W){1'b0}}, out_root_q};
	assign m_axis_tuser  = out_same_q;

	// Drive table accesses for the current step
	always_comb begin
		tbl        = '0;
		find_done  = 1'b0;
		found_root = root_q;
		unique case (state_q)
			dsu_pkg::S_IDLE: begin
				if (accept) begin
					tbl.rd_en   = 1'b1;
					tbl.rd_addr = in_a;
				end
			end
			dsu_pkg::S_WALK: begin
				if (rd_data == cur_q) begin
					found_root = cur_q;
					if (cur_q == start_q) begin
						find_done = 1'b1;
					end else begin
						tbl.rd_en   = 1'b1;
						tbl.rd_addr = start_q;
					end
				end else begin
					tbl.rd_en   = 1'b1;
					tbl.rd_addr = rd_data;
				end
			end
			dsu_pkg::S_COMP: begin
				tbl.wr_en   = 1'b1;
				tbl.wr_addr = cur_q;
				tbl.wr_data = root_q;
				if (rd_data == root_q) begin
					find_done = 1'b1;
				end else begin
					tbl.rd_en   = 1'b1;
					tbl.rd_addr = rd_data;
				end
			end
			dsu_pkg::S_DONE: begin
				if (out_free && req_q == dsu_pkg::REQ_UNION) begin
					tbl.wr_en   = 1'b1;
					tbl.wr_addr = hi_root;
					tbl.wr_data = lo_root;
				end
			end
			default: begin
				tbl = '0;
			end
		endcase
		// Start the second find right after the first
		if (find_done && !which_q) begin
			tbl.rd_en   = 1'b1;
			tbl.rd_addr = b_q;
		end
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsu_pkg::S_IDLE;
			which_q <= 1'b0;
		end else begin
			unique case (state_q) inside
				dsu_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= dsu_pkg::S_WALK;
						which_q <= 1'b0;
					end
				end
				dsu_pkg::S_WALK, dsu_pkg::S_COMP: begin
					if (find_done) begin
						if (!which_q) begin
							state_q <= dsu_pkg::S_WALK;
							which_q <= 1'b1;
						end else begin
							state_q <= dsu_pkg::S_DONE;
						end
					end else if (state_q == dsu_pkg::S_WALK && rd_data == cur_q) begin
						state_q <= dsu_pkg::S_COMP;
					end
				end
				dsu_pkg::S_DONE: begin
					if (out_free) begin
						state_q <= dsu_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= dsu_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Hold walk pointers and found roots
	always_ff @(posedge clk) begin
		case (state_q) inside
			dsu_pkg::S_IDLE: begin
				if (accept) begin
					cur_q   <= in_a;
					start_q <= in_a;
					b_q     <= in_b;
					req_q   <= s_axis_tuser;
				end
			end
			dsu_pkg::S_WALK, dsu_pkg::S_COMP: begin
				if (find_done) begin
					if (!which_q) begin
						ra_q <= found_root;
					end else begin
						rb_q <= found_root;
					end
					cur_q   <= b_q;
					start_q <= b_q;
				end else if (state_q == dsu_pkg::S_WALK && rd_data == cur_q) begin
					root_q <= cur_q;
					cur_q  <= start_q;
				end else begin
					cur_q <= rd_data;
				end
			end
			default: begin
			end
		endcase
	end

	// Load the output register; keep it until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == dsu_pkg::S_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dsu_pkg::S_DONE && out_free) begin
			out_root_q <= (req_q == dsu_pkg::REQ_QUERY) ? ra_q : lo_root;
			out_same_q <= (ra_q == rb_q);
		end
	end

	// A parent never exceeds its node
	assert property (@(posedge clk) disable iff (!arst_n)
		tbl.wr_en |-> (tbl.wr_data <= tbl.wr_addr))
		else $error("parent written above its node");

	// Walk steps only toward smaller indexes
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dsu_pkg::S_WALK) |-> (rd_data <= cur_q))
		else $error("walk read a parent above its node");

	// No table writes while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dsu_pkg::S_IDLE) |-> !tbl.wr_en)
		else $error("table write while idle");

	// A result appears only after the final step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == dsu_pkg::S_DONE))
		else $error("result raised outside done step");

endmodule
